>>> sv/mel_pkg.sv
// Shared types and constants of the masked Euclidean loss block.
package mel_pkg;

   localparam int LANES        = 4;
   localparam int MAX_CHANNELS = 4;
   localparam int LANE_LIMIT   = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;
   localparam int LANE_CNT_W   = 3;
   localparam int DATA_W       = 16;
   localparam int DIFF_W       = DATA_W + 1;
   localparam int SQ_W         = 32;
   localparam int SUM_W        = 64;
   localparam int LOSS_W       = 62;
   localparam int REQ_DATA_W   = 2 * LANES * DATA_W;
   localparam int RSP_PAY_W    = LANES * DIFF_W + LOSS_W;
   localparam int RSP_DATA_W   = ((RSP_PAY_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_PAY_W;
   localparam int RSP_USER_W   = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LABEL_THRESHOLD = 1'b0,
      REG_CHANNELS_IN_USE = 1'b1
   } csr_reg_type;

   // One classified pixel, as handed from the front end to the back end.
   typedef struct packed {
      logic [LANES-1:0][DIFF_W-1:0] diff;
      logic                         pixel_valid;
      logic [LANE_CNT_W-1:0]        lanes;
      logic                         last;
   } mel_entry_type;

endpackage

>>> sv/masked_euclidean_loss.sv
// Masked Euclidean loss: one pixel per transfer in, one result per pixel out. A pixel counts
// when any used label lane reaches the threshold; each result carries the masked differences,
// and the result of the pixel flagged by req_tlast also carries floor(sum/2/count) of the
// batch and clears the sum and the count. Pixels are taken one per cycle while the queue is not
// full; with no stall a result is offered once its pixel has passed the queue slot, the square
// stage and the result register. A last pixel with a nonzero count holds the back end while
// the divider makes one quotient bit per cycle; a four-entry queue keeps taking pixels during that time until it fills.
module masked_euclidean_loss #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mel_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mel_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pred_0, pred_1, pred_2, pred_3, label_0, label_1, label_2, label_3
   input  logic [mel_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // diff_0, diff_1, diff_2, diff_3, loss_value, zero fill
   output logic [mel_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // pixel_valid, no_valid_elements
   output logic [mel_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);
   import mel_pkg::*;

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_empty;
   mel_entry_type push_entry;
   mel_entry_type head_entry;

   mel_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   mel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   mel_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sv/mel_front.sv
// Front end: configuration registers, pixel validity test and lane differences.
module mel_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mel_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mel_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mel_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   input  logic                                q_full,
   output logic                                q_push,
   output mel_pkg::mel_entry_type              q_entry
);
   import mel_pkg::*;

   logic signed [DATA_W-1:0]     threshold_ff;
   logic signed [DATA_W-1:0]     threshold_in;
   logic [LANE_CNT_W-1:0]        channels_ff;
   logic [LANE_CNT_W-1:0]        channels_in;
   logic [LANE_CNT_W-1:0]        lanes;
   logic [LANES-1:0]             hit;
   logic [DATA_W-1:0]            pred;
   logic [DATA_W-1:0]            label;

   function automatic logic [LANE_CNT_W-1:0] clamp_lanes(input logic [LANE_CNT_W-1:0] ch);
      logic [LANE_CNT_W-1:0] n;
      n = ch;
      if (n == '0) begin
         n = LANE_CNT_W'(1);
      end
      if (n > LANE_CNT_W'(LANE_LIMIT)) begin
         n = LANE_CNT_W'(LANE_LIMIT);
      end
      return n;
   endfunction

   always_comb begin
      threshold_in = threshold_ff;
      channels_in  = channels_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_LABEL_THRESHOLD: threshold_in = csr_wdata[DATA_W-1:0];
            REG_CHANNELS_IN_USE: channels_in  = csr_wdata[LANE_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= DATA_W'(1);
         channels_ff  <= LANE_CNT_W'(1);
      end else begin
         threshold_ff <= threshold_in;
         channels_ff  <= channels_in;
      end
   end

   assign lanes = clamp_lanes(channels_ff);

   always_comb begin
      pred  = '0;
      label = '0;
      for (int c = 0; c < LANES; c++) begin
         label  = req_tdata[(LANES + c) * DATA_W +: DATA_W];
         hit[c] = (LANE_CNT_W'(c) < lanes) && ($signed(label) >= threshold_ff);
      end
      q_entry.pixel_valid = |hit;
      q_entry.lanes       = lanes;
      q_entry.last        = req_tlast;
      for (int c = 0; c < LANES; c++) begin
         pred  = req_tdata[c * DATA_W +: DATA_W];
         label = req_tdata[(LANES + c) * DATA_W +: DATA_W];
         if (q_entry.pixel_valid && (LANE_CNT_W'(c) < lanes)) begin
            q_entry.diff[c] = {pred[DATA_W-1], pred} - {label[DATA_W-1], label};
         end else begin
            q_entry.diff[c] = '0;
         end
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

>>> sv/mel_queue.sv
// Short queue of classified pixels between the front end and the back end.
module mel_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mel_pkg::mel_entry_type  push_entry,
   output logic                    full,
   input  logic                    pop,
   output mel_pkg::mel_entry_type  head_entry,
   output logic                    empty
);
   import mel_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   mel_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [PTR_W:0]    fill_ff;
   logic [PTR_W:0]    fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = slot_ff[rd_ptr_ff];
   assign full       = (fill_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign empty      = (fill_ff == '0);

endmodule

>>> sv/mel_div.sv
// Restoring divider that produces one quotient bit per cycle.
module mel_div #(
   parameter int DIVIDEND_W = 63,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVIDEND_W-1:0] quo_in;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [DIVISOR_W-1:0]  den_in;
   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    reduced;
   logic                  fits;

   assign trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = (trial >= {1'b0, den_ff});
   assign reduced = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         step_in = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? reduced[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/mel_back.sv
// Back end: squares, saturating accumulation, final divide and the result register.
module mel_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  mel_pkg::mel_entry_type              q_entry,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mel_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [mel_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);
   import mel_pkg::*;

   localparam int QUO_W = SUM_W - 1;

   typedef enum logic {ST_RUN, ST_DIVIDE} state_type;

   state_type                     state_ff, state_in;
   logic                          s1_valid_ff, s1_valid_in;
   mel_entry_type                 s1_entry_ff, s1_entry_in;
   logic [LANES-1:0][SQ_W-1:0]    s1_sq_ff, s1_sq_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LANES-1:0][DIFF_W-1:0]  diff_ff, diff_in;
   logic [LOSS_W-1:0]             loss_ff, loss_in;
   logic                          pixel_valid_ff, pixel_valid_in;
   logic                          last_ff, last_in;
   logic                          empty_flag_ff, empty_flag_in;

   logic signed [2*DIFF_W-1:0]    prod [LANES];
   logic [SQ_W+1:0]               sq_total;
   logic [SUM_W:0]                sum_add;
   logic [COUNT_WIDTH:0]          count_add;
   logic [SUM_W-1:0]              sum_new;
   logic [COUNT_WIDTH-1:0]        count_new;
   logic                          out_free;
   logic                          s1_take;
   logic                          s1_pop;
   logic                          div_start;
   logic                          div_done;
   logic [QUO_W-1:0]              quotient;

   mel_div #(
      .DIVIDEND_W (QUO_W),
      .DIVISOR_W  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new[SUM_W-1:1]),
      .divisor  (count_new),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         prod[c]     = $signed(q_entry.diff[c]) * $signed(q_entry.diff[c]);
         s1_sq_in[c] = prod[c][SQ_W-1:0];
      end
   end

   // Saturating accumulation of the pixel waiting in the square stage.
   always_comb begin
      sq_total = '0;
      for (int c = 0; c < LANES; c++) begin
         sq_total = sq_total + (SQ_W + 2)'(s1_sq_ff[c]);
      end
      sum_add   = {1'b0, sum_ff} + (SUM_W + 1)'(sq_total);
      count_add = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(s1_entry_ff.lanes);
      sum_new   = sum_ff;
      count_new = count_ff;
      if (s1_entry_ff.pixel_valid) begin
         sum_new   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         count_new = count_add[COUNT_WIDTH] ? '1 : count_add[COUNT_WIDTH-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      diff_in        = diff_ff;
      loss_in        = loss_ff;
      pixel_valid_in = pixel_valid_ff;
      last_in        = last_ff;
      empty_flag_in  = empty_flag_ff;
      s1_take        = 1'b0;
      s1_pop         = 1'b0;
      div_start      = 1'b0;

      case (state_ff)
         ST_RUN: begin
            if (s1_valid_ff) begin
               if (s1_entry_ff.last && (count_new != '0)) begin
                  s1_take = 1'b1;
               end else begin
                  s1_take = out_free;
               end
            end
            if (s1_take) begin
               sum_in   = sum_new;
               count_in = count_new;
               if (s1_entry_ff.last) begin
                  sum_in   = '0;
                  count_in = '0;
               end
               if (s1_entry_ff.last && (count_new != '0)) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  s1_pop         = 1'b1;
                  rsp_valid_in   = 1'b1;
                  diff_in        = s1_entry_ff.diff;
                  pixel_valid_in = s1_entry_ff.pixel_valid;
                  loss_in        = '0;
                  last_in        = s1_entry_ff.last;
                  empty_flag_in  = s1_entry_ff.last;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done && out_free) begin
               s1_pop         = 1'b1;
               state_in       = ST_RUN;
               rsp_valid_in   = 1'b1;
               diff_in        = s1_entry_ff.diff;
               pixel_valid_in = s1_entry_ff.pixel_valid;
               loss_in        = quotient[QUO_W-1] ? '1 : quotient[LOSS_W-1:0];
               last_in        = 1'b1;
               empty_flag_in  = 1'b0;
            end
         end
         default: state_in = ST_RUN;
      endcase

      q_pop       = !q_empty && (!s1_valid_ff || s1_pop);
      s1_valid_in = q_pop || (s1_valid_ff && !s1_pop);
      s1_entry_in = q_pop ? q_entry : s1_entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_entry_ff    <= s1_entry_in;
      if (q_pop) begin
         s1_sq_ff <= s1_sq_in;
      end
      diff_ff        <= diff_in;
      loss_ff        <= loss_in;
      pixel_valid_ff <= pixel_valid_in;
      last_ff        <= last_in;
      empty_flag_ff  <= empty_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, loss_ff, diff_ff};
   assign rsp_tuser  = {empty_flag_ff, pixel_valid_ff};
   assign rsp_tlast  = last_ff;

   a_divide_holds_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> s1_valid_ff && s1_entry_ff.last)
      else $error("divide running without a last pixel in the square stage");

   a_loss_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> loss_ff == '0 && !empty_flag_ff)
      else $error("loss fields set on a result that is not the last of a batch");

   a_empty_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && empty_flag_ff |-> loss_ff == '0)
      else $error("empty batch reported with a nonzero loss");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_take && s1_entry_ff.last |=> sum_ff == '0 && count_ff == '0)
      else $error("accumulators not cleared after the last pixel");

endmodule
